// ===== rtl/mbrg_pkg.sv =====
// Package for the Margolus block-rotation grid: sizes, command codes and
// the controller/datapath command and status types. No dependencies.
`timescale 1ns / 1ps

package mbrg_pkg;

	// Grid geometry; rows and columns must both be even.
	localparam int ROWS      = 64;
	localparam int COLS      = 64;
	localparam int CELL_BITS = 16;

	localparam int ROW_AW    = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int COL_AW    = (COLS > 1) ? $clog2(COLS) : 1;
	localparam int ROW_BITS  = COLS * CELL_BITS;
	localparam int MASK_BITS = 32;

	// Word field widths
	localparam int CMD_W   = 2;
	localparam int IDX_W   = 6;
	localparam int VALUE_W = 16;

	localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_ROTATE = 2'd2;

	typedef logic [CELL_BITS-1:0]          cell_t;
	typedef logic [COLS-1:0][CELL_BITS-1:0] row_t;
	typedef logic [ROW_AW-1:0]             row_addr_t;

	// Controller to datapath
	typedef struct packed {
		logic      load_in;
		logic      rd_en;
		logic      rd_bot;
		logic      cap_top;
		logic      cap_bot;
		logic      wr_en;
		logic      wr_bot;
		logic      clear;
		row_addr_t clr_addr;
		logic      load_out;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic wr_top_ok;
		logic wr_bot_ok;
	} dp_stat_t;

endpackage

// ===== rtl/mbrg_if.sv =====
// Handshake channels of the grid: command words in, result words out.
// Depends on mbrg_pkg for field widths.
`timescale 1ns / 1ps

interface mbrg_in_if;
	logic                             valid;
	logic                             ready;
	logic [mbrg_pkg::CMD_W-1:0]       command;
	logic [mbrg_pkg::IDX_W-1:0]       row;
	logic [mbrg_pkg::IDX_W-1:0]       col;
	logic [mbrg_pkg::VALUE_W-1:0]     cell_value;
	logic                             phase;
	logic [mbrg_pkg::MASK_BITS-1:0]   turn_mask;

	modport source (output valid, command, row, col, cell_value, phase, turn_mask,
		input ready);
	modport sink (input valid, command, row, col, cell_value, phase, turn_mask,
		output ready);
endinterface

interface mbrg_out_if;
	logic                         valid;
	logic                         ready;
	logic [mbrg_pkg::VALUE_W-1:0] read_value;
	logic [mbrg_pkg::CMD_W-1:0]   done_command;

	modport source (output valid, read_value, done_command, input ready);
	modport sink (input valid, read_value, done_command, output ready);
endinterface

// ===== rtl/margolus_block_rotation_grid.sv =====
// Top level of the Margolus block-rotation grid: controller plus datapath.
// Depends on mbrg_pkg, mbrg_if, mbrg_ctrl and mbrg_dp.
//
//   channel   dir   word fields
//   in_ch     in    command, row, col, cell_value, phase, turn_mask
//   out_ch    out   read_value, done_command
//
// Sequence: after acceptance a word reads the top row, reads the bottom row,
// captures, writes top, writes bottom and hands its result over; the next
// word can be accepted in the cycle after the hand-over, so words never
// overlap; the single-read grid RAM, one row-wide word per grid row, sets this.
// Reset: arst_n clears control; a clearing pass over all ROWS (64) rows then
// zeroes the grid one row a cycle, with in_ch.ready low throughout.
// Stalls: a result waits in the output register while out_ch.ready is low;
// the next word is accepted once that result has been loaded, and a finished
// result holds in_ch.ready low until the output register is free for it.
`timescale 1ns / 1ps

module margolus_block_rotation_grid (
	input  logic         clk,
	input  logic         arst_n,
	mbrg_in_if.sink      in_ch,
	mbrg_out_if.source   out_ch
);

	mbrg_pkg::dp_cmd_t  dp_cmd;
	mbrg_pkg::dp_stat_t dp_stat;

	// Sequence the row reads and writes for one word at a time
	mbrg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready),
		.cmd      (dp_cmd),
		.stat     (dp_stat)
	);

	// Hold the grid, turn block rows and build the result word
	mbrg_dp u_dp (
		.clk         (clk),
		.cmd         (dp_cmd),
		.stat        (dp_stat),
		.in_ch       (in_ch),
		.read_value  (out_ch.read_value),
		.done_command(out_ch.done_command)
	);

endmodule

// ===== rtl/mbrg_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mbrg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic                                         re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/mbrg_dp.sv =====
// Datapath: command register, row-wide grid RAM, row pair buffers, block
// rotation network and result register. Depends on mbrg_pkg and mbrg_ram.
`timescale 1ns / 1ps

module mbrg_dp (
	input  logic               clk,
	input  mbrg_pkg::dp_cmd_t  cmd,
	output mbrg_pkg::dp_stat_t stat,
	mbrg_in_if.sink            in_ch,
	output logic [mbrg_pkg::VALUE_W-1:0] read_value,
	output logic [mbrg_pkg::CMD_W-1:0]   done_command
);

	logic [mbrg_pkg::CMD_W-1:0]     cmd_q;
	logic [mbrg_pkg::IDX_W-1:0]     row_q;
	logic [mbrg_pkg::IDX_W-1:0]     col_q;
	logic [mbrg_pkg::VALUE_W-1:0]   val_q;
	logic                           phase_q;
	logic [mbrg_pkg::MASK_BITS-1:0] mask_q;

	mbrg_pkg::row_t top_q, bot_q;
	mbrg_pkg::row_t at_w, ab_w, rt_w, rb_w, new_top, new_bot, cell_row;
	mbrg_pkg::row_t wr_data, rd_data;

	mbrg_pkg::row_addr_t top_addr, bot_addr, rd_addr, wr_addr;
	logic [mbrg_pkg::COL_AW-1:0] col_idx;
	logic cell_ok, rot_ok, is_rot;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			cmd_q   <= in_ch.command;
			row_q   <= in_ch.row;
			col_q   <= in_ch.col;
			val_q   <= in_ch.cell_value;
			phase_q <= in_ch.phase;
			mask_q  <= in_ch.turn_mask;
		end
		if (cmd.cap_top) begin
			top_q <= rd_data;
		end
		if (cmd.cap_bot) begin
			bot_q <= rd_data;
		end
		if (cmd.load_out) begin
			read_value   <= (cmd_q == mbrg_pkg::CMD_READ && cell_ok)
				? mbrg_pkg::VALUE_W'(top_q[col_idx]) : '0;
			done_command <= cmd_q;
		end
	end

	assign is_rot  = (cmd_q == mbrg_pkg::CMD_ROTATE);
	assign cell_ok = (32'(row_q) < 32'(mbrg_pkg::ROWS)) && (32'(col_q) < 32'(mbrg_pkg::COLS));
	assign rot_ok  = 32'(row_q) < 32'(mbrg_pkg::ROWS / 2);
	assign col_idx = mbrg_pkg::COL_AW'(col_q);

	// Top row of the block row is 2r+phase; bottom wraps at the last row
	assign top_addr = is_rot ? mbrg_pkg::ROW_AW'({row_q, phase_q})
		: mbrg_pkg::ROW_AW'(row_q);
	assign bot_addr = (top_addr == mbrg_pkg::ROW_AW'(mbrg_pkg::ROWS - 1)) ? '0
		: top_addr + mbrg_pkg::ROW_AW'(1);

	assign stat.wr_top_ok = (cmd_q == mbrg_pkg::CMD_WRITE && cell_ok) || (is_rot && rot_ok);
	assign stat.wr_bot_ok = is_rot && rot_ok;

	// Align so that every block starts at an even column, turn, then undo
	always_comb begin
		for (int c = 0; c < mbrg_pkg::COLS; c++) begin
			at_w[c] = phase_q ? top_q[(c + 1) % mbrg_pkg::COLS] : top_q[c];
			ab_w[c] = phase_q ? bot_q[(c + 1) % mbrg_pkg::COLS] : bot_q[c];
		end
		rt_w = at_w;
		rb_w = ab_w;
		for (int b = 0; b < mbrg_pkg::COLS / 2; b++) begin
			if ((b < mbrg_pkg::MASK_BITS) && mask_q[b % mbrg_pkg::MASK_BITS]) begin
				rb_w[2*b]     = at_w[2*b];
				rt_w[2*b]     = at_w[2*b+1];
				rt_w[2*b+1]   = ab_w[2*b+1];
				rb_w[2*b+1]   = ab_w[2*b];
			end else begin
				rt_w[2*b+1]   = at_w[2*b];
				rt_w[2*b]     = ab_w[2*b];
				rb_w[2*b]     = ab_w[2*b+1];
				rb_w[2*b+1]   = at_w[2*b+1];
			end
		end
		for (int c = 0; c < mbrg_pkg::COLS; c++) begin
			new_top[c] = phase_q ? rt_w[(c + mbrg_pkg::COLS - 1) % mbrg_pkg::COLS] : rt_w[c];
			new_bot[c] = phase_q ? rb_w[(c + mbrg_pkg::COLS - 1) % mbrg_pkg::COLS] : rb_w[c];
		end
	end

	always_comb begin
		cell_row          = top_q;
		cell_row[col_idx] = mbrg_pkg::CELL_BITS'(val_q);
	end

	always_comb begin
		if (cmd.clear) begin
			wr_data = '0;
			wr_addr = cmd.clr_addr;
		end else if (cmd.wr_bot) begin
			wr_data = new_bot;
			wr_addr = bot_addr;
		end else begin
			wr_data = is_rot ? new_top : cell_row;
			wr_addr = top_addr;
		end
	end

	assign rd_addr = cmd.rd_bot ? bot_addr : top_addr;

	mbrg_ram #(
		.WIDTH(mbrg_pkg::ROW_BITS),
		.DEPTH(mbrg_pkg::ROWS)
	) u_grid (
		.clk  (clk),
		.we   (cmd.wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.re   (cmd.rd_en),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

endmodule

// ===== rtl/mbrg_ctrl.sv =====
// Controller: clearing pass after reset, per-word read/modify/write
// sequence and result valid. Depends on mbrg_pkg.
`timescale 1ns / 1ps

module mbrg_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output mbrg_pkg::dp_cmd_t  cmd,
	input  mbrg_pkg::dp_stat_t stat
);

	typedef enum logic [6:0] {
		S_CLEAR = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_RD_A  = 7'b0000100,
		S_RD_B  = 7'b0001000,
		S_CAP   = 7'b0010000,
		S_WR_A  = 7'b0100000,
		S_WR_B  = 7'b1000000
	} state_t;

	// S_DONE folded: result hand-off happens in S_WR_B's successor check
	typedef enum logic [1:0] {
		O_WORK = 2'b01,
		O_DONE = 2'b10
	} done_t;

	state_t              state_q, state_d;
	done_t               done_q, done_d;
	mbrg_pkg::row_addr_t clr_q;
	logic                out_valid_q;
	logic                accept, out_free;

	assign in_ready = (state_q == S_IDLE) && (done_q == O_WORK);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		done_d  = done_q;
		cmd     = '0;
		cmd.clr_addr = clr_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				cmd.wr_en = 1'b1;
				if (clr_q == mbrg_pkg::ROW_AW'(mbrg_pkg::ROWS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				// Hand over the finished word, then take the next one
				if (done_q == O_DONE) begin
					if (out_free) begin
						cmd.load_out = 1'b1;
						done_d = O_WORK;
					end
				end else if (accept) begin
					cmd.load_in = 1'b1;
					state_d = S_RD_A;
				end
			end
			S_RD_A: begin
				cmd.rd_en = 1'b1;
				state_d = S_RD_B;
			end
			S_RD_B: begin
				cmd.cap_top = 1'b1;
				cmd.rd_en   = 1'b1;
				cmd.rd_bot  = 1'b1;
				state_d = S_CAP;
			end
			S_CAP: begin
				cmd.cap_bot = 1'b1;
				state_d = S_WR_A;
			end
			S_WR_A: begin
				cmd.wr_en = stat.wr_top_ok;
				state_d = S_WR_B;
			end
			S_WR_B: begin
				cmd.wr_en  = stat.wr_bot_ok;
				cmd.wr_bot = 1'b1;
				state_d = S_IDLE;
				done_d  = O_DONE;
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			done_q      <= O_WORK;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + mbrg_pkg::ROW_AW'(1);
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_load_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> out_free)
		else $error("result loaded over an untaken word");

	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_RD_A)
		else $error("accepted word did not start its row read");

	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_en |-> (state_q == S_CLEAR || state_q == S_WR_A || state_q == S_WR_B))
		else $error("grid write outside a write step");

	a_clear_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR && clr_q == mbrg_pkg::ROW_AW'(mbrg_pkg::ROWS - 1))
		|=> (state_q == S_IDLE && clr_q == '0))
		else $error("clearing pass did not finish cleanly");

endmodule

// ===== tb/sv/tb_grid_pkg.sv =====
// Word types and the grid mirror scoreboard for the block-rotation grid bench.
// Depends on mbrg_pkg for the grid size, field widths and command codes.
`timescale 1ns / 1ps

package tb_grid_pkg;
	import mbrg_pkg::*;

	// The package names three codes; the fourth is still a legal word.
	localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0]     command;
		logic [IDX_W-1:0]     row;
		logic [IDX_W-1:0]     col;
		logic [VALUE_W-1:0]   cell_value;
		logic                 phase;
		logic [MASK_BITS-1:0] turn_mask;
	} grid_word_t;

	typedef struct packed {
		logic [VALUE_W-1:0] read_value;
		logic [CMD_W-1:0]   done_command;
	} grid_result_t;

	class grid_mirror;
		cell_t        cells [ROWS][COLS];
		grid_result_t pending_results [$];
		int           mismatches;
		int           results_seen;
		int           nonzero_reads;
		int           words_by_cmd [4];

		function new();
			foreach (cells[r, c]) cells[r][c] = '0;
			mismatches    = 0;
			results_seen  = 0;
			nonzero_reads = 0;
			foreach (words_by_cmd[i]) words_by_cmd[i] = 0;
		endfunction

		task report(string msg);
			$display("[grid_mirror] %s", msg);
			mismatches++;
		endtask

		// Turn every 2x2 block of one block row, wrapping at the torus edges.
		function void turn_row(int block_row, logic ph, logic [MASK_BITS-1:0] mask);
			int    t0, t1, l0, l1, left;
			bit    ccw;
			cell_t held;
			t0 = (2 * block_row + ph) % ROWS;
			t1 = (2 * block_row + ph + 1) % ROWS;
			for (int b = 0; b < COLS / 2; b++) begin
				left = 2 * b + ph;
				l0 = left % COLS;
				l1 = (left + 1) % COLS;
				ccw = (b < MASK_BITS) && mask[b];
				if (ccw) begin
					held          = cells[t1][l0];
					cells[t1][l0] = cells[t0][l0];
					cells[t0][l0] = cells[t0][l1];
					cells[t0][l1] = cells[t1][l1];
					cells[t1][l1] = held;
				end else begin
					held          = cells[t0][l1];
					cells[t0][l1] = cells[t0][l0];
					cells[t0][l0] = cells[t1][l0];
					cells[t1][l0] = cells[t1][l1];
					cells[t1][l1] = held;
				end
			end
		endfunction

		// Note one accepted word: update the mirror and queue its result.
		function void apply_word(grid_word_t w);
			grid_result_t res;
			bit           on_grid;
			on_grid = (int'(w.row) < ROWS) && (int'(w.col) < COLS);
			res.read_value   = '0;
			res.done_command = w.command;
			case (w.command)
				CMD_WRITE: begin
					if (on_grid) cells[w.row][w.col] = w.cell_value[CELL_BITS-1:0];
				end
				CMD_READ: begin
					if (on_grid) res.read_value = VALUE_W'(cells[w.row][w.col]);
				end
				CMD_ROTATE: begin
					if (int'(w.row) < ROWS / 2) turn_row(int'(w.row), w.phase, w.turn_mask);
				end
				default: ;
			endcase
			pending_results = {pending_results, res};
			words_by_cmd[w.command]++;
		endfunction

		task check_result(grid_result_t got);
			grid_result_t want;
			results_seen++;
			if (pending_results.size() == 0) begin
				report($sformatf("unexpected result: read_value %h done_command %0d",
					got.read_value, got.done_command));
			end else begin
				want = pending_results.pop_front();
				if (got.read_value !== want.read_value)
					report($sformatf("read_value %h, want %h (command %0d)",
						got.read_value, want.read_value, want.done_command));
				if (got.done_command !== want.done_command)
					report($sformatf("done_command %0d, want %0d",
						got.done_command, want.done_command));
				if (want.done_command == CMD_READ && want.read_value != '0)
					nonzero_reads++;
			end
		endtask

		task check_drained();
			if (pending_results.size() != 0)
				report($sformatf("%0d results never arrived", pending_results.size()));
		endtask
	endclass

endpackage

// ===== tb/sv/tb_top.sv =====
// Top-level bench for margolus_block_rotation_grid: drives command words with
// random gaps, stalls the result channel and checks every result against
// grid_mirror. Depends on mbrg_pkg, mbrg_if, tb_grid_pkg and the grid RTL.
`timescale 1ns / 1ps

module tb_top;
	import mbrg_pkg::*;
	import tb_grid_pkg::*;

	// Ceiling on the whole run, in clock cycles.
	localparam int CYCLE_LIMIT = 500_000;
	// Directed words plus the random body.
	localparam int WORD_TARGET = 1575;

	logic clk;
	logic arst_n;

	mbrg_in_if  in_ch ();
	mbrg_out_if out_ch ();

	margolus_block_rotation_grid dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	grid_mirror mirror = new();

	int words_sent  = 0;
	int feed_calm   = 0;
	int drain_calm  = 0;
	int diffusion_passes = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hold every input at a known value from time zero; release reset at a falling edge.
	initial begin
		arst_n           = 1'b0;
		in_ch.valid      = 1'b0;
		in_ch.command    = '0;
		in_ch.row        = '0;
		in_ch.col        = '0;
		in_ch.cell_value = '0;
		in_ch.phase      = 1'b0;
		in_ch.turn_mask  = '0;
		out_ch.ready     = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Draw a random wait; now and then start a stretch of zero waits so that words
	// also go back to back as fast as the grid takes them.
	function automatic int draw_wait(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0) begin
			calm = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 16);
	endfunction

	// Present one word after a random gap, hold it until accepted, then note it.
	// Inputs change only at the falling edge; ready is sampled at the rising edge.
	task automatic send_word(input logic [CMD_W-1:0] cmd, input int row, input int col,
		input logic [VALUE_W-1:0] value, input logic ph, input logic [MASK_BITS-1:0] mask);
		grid_word_t w;
		int         gap;
		w.command    = cmd;
		w.row        = IDX_W'(row);
		w.col        = IDX_W'(col);
		w.cell_value = value;
		w.phase      = ph;
		w.turn_mask  = mask;
		gap = draw_wait(feed_calm);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.command    <= w.command;
		in_ch.row        <= w.row;
		in_ch.col        <= w.col;
		in_ch.cell_value <= w.cell_value;
		in_ch.phase      <= w.phase;
		in_ch.turn_mask  <= w.turn_mask;
		in_ch.valid      <= 1'b1;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		mirror.apply_word(w);
		words_sent++;
		@(negedge clk);
	endtask

	// Shorthands; unused fields still carry random bits.
	task automatic write_cell(input int row, input int col, input logic [VALUE_W-1:0] value);
		send_word(CMD_WRITE, row, col, value, 1'($urandom), $urandom);
	endtask

	task automatic read_cell(input int row, input int col);
		send_word(CMD_READ, row, col, VALUE_W'($urandom), 1'($urandom), $urandom);
	endtask

	task automatic rotate_row(input int block_row, input logic ph,
		input logic [MASK_BITS-1:0] mask);
		send_word(CMD_ROTATE, block_row, $urandom_range(0, 63), VALUE_W'($urandom), ph, mask);
	endtask

	// Directed opening: corners, both turn senses, wrap at both torus edges,
	// rotates past the last block row, the unknown command and an empty write.
	task automatic run_directed();
		write_cell(0, 0, 16'hFFFF);
		write_cell(0, 1, 16'h0001);
		write_cell(1, 0, 16'h8000);
		write_cell(1, 1, 16'h00A5);
		rotate_row(0, 1'b0, 32'h0000_0001);    // block 0 counter-clockwise
		read_cell(0, 0);
		read_cell(0, 1);
		read_cell(1, 0);
		read_cell(1, 1);
		rotate_row(0, 1'b0, 32'h0000_0000);    // whole row clockwise
		write_cell(63, 63, 16'h1234);
		write_cell(63, 0, 16'h5678);
		write_cell(0, 63, 16'h9ABC);
		rotate_row(31, 1'b1, 32'hFFFF_FFFF);   // last block wraps over the corner
		read_cell(0, 0);
		read_cell(63, 63);
		rotate_row(32, 1'b0, $urandom);        // first block row beyond the grid
		rotate_row(63, 1'b1, 32'hFFFF_FFFF);   // highest row index, no change
		send_word(CMD_UNKNOWN, 63, 63, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
		read_cell(63, 0);
		write_cell(5, 5, 16'h0000);
		read_cell(5, 5);
		read_cell(0, 63);
	endtask

	// Well-formed episode: seed a pair of grid rows, turn their block row a few
	// times, then read back inside the blocks that the written cells sit in.
	task automatic run_patch_episode();
		int block_row, top, col, lead, row;
		int written [$];
		logic ph;
		block_row = $urandom_range(0, ROWS / 2 - 1);
		ph        = 1'($urandom);
		top       = 2 * block_row + ph;
		repeat ($urandom_range(1, 6)) begin
			col = $urandom_range(0, COLS - 1);
			row = (top + $urandom_range(0, 1)) % ROWS;
			write_cell(row, col, ($urandom_range(0, 7) == 0) ? 16'h0000 : VALUE_W'($urandom));
			written = {written, col};
		end
		repeat ($urandom_range(1, 3)) rotate_row(block_row, ph, $urandom);
		repeat ($urandom_range(2, 6)) begin
			col  = written[$urandom_range(0, written.size() - 1)];
			lead = (((col - ph + COLS) % COLS) & ~1) + ph;
			read_cell((top + $urandom_range(0, 1)) % ROWS, (lead + $urandom_range(0, 1)) % COLS);
		end
	endtask

	// Random body: mostly patch episodes, some free-form noise over every field,
	// scattered reads and the odd full diffusion pass (phase 0, then phase 1).
	task automatic run_random();
		int pick;
		while (words_sent < WORD_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				run_patch_episode();
			end else if (pick < 85) begin
				send_word(CMD_W'($urandom), $urandom_range(0, 63), $urandom_range(0, 63),
					VALUE_W'($urandom), 1'($urandom), $urandom);
			end else if (pick < 87 && diffusion_passes < 4) begin
				diffusion_passes++;
				for (int ph = 0; ph < 2; ph++)
					for (int r = 0; r < ROWS / 2; r++)
						rotate_row(r, 1'(ph), $urandom);
			end else begin
				repeat ($urandom_range(1, 4))
					read_cell($urandom_range(0, ROWS - 1), $urandom_range(0, COLS - 1));
			end
		end
	endtask

	// Result side: stall at random, then take whatever word arrives.
	initial begin
		grid_result_t got;
		int stall;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			stall = draw_wait(drain_calm);
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (out_ch.valid !== 1'b1);
			got.read_value   = out_ch.read_value;
			got.done_command = out_ch.done_command;
			mirror.check_result(got);
			@(negedge clk);
		end
	end

	// Watchdog: count cycles and give up at the ceiling.
	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("[tb_top] timeout after %0d cycles, %0d results pending", cycles,
			mirror.pending_results.size());
		$display("tb_top failed");
		$finish;
	end

	// Main sequence: reset, directed words, random body, drain, verdict.
	initial begin
		wait (arst_n === 1'b1);
		@(negedge clk);
		run_directed();
		run_random();
		in_ch.valid <= 1'b0;
		while (mirror.pending_results.size() != 0) @(posedge clk);
		// Keep waiting afterwards so that any stray word can still show up.
		repeat (32) @(posedge clk);
		mirror.check_drained();
		$display("[tb_top] %0d words: %0d writes, %0d reads, %0d rotates, %0d unknown",
			words_sent, mirror.words_by_cmd[CMD_WRITE], mirror.words_by_cmd[CMD_READ],
			mirror.words_by_cmd[CMD_ROTATE], mirror.words_by_cmd[CMD_UNKNOWN]);
		$display("[tb_top] %0d results checked, %0d reads returned data, %0d diffusion passes",
			mirror.results_seen, mirror.nonzero_reads, diffusion_passes);
		if (mirror.mismatches == 0) begin
			$display("tb_top passed");
		end else begin
			$display("[tb_top] %0d mismatches", mirror.mismatches);
			$display("tb_top failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/mbrg_pkg.sv
rtl/mbrg_if.sv
rtl/mbrg_ram.sv
rtl/mbrg_dp.sv
rtl/mbrg_ctrl.sv
rtl/margolus_block_rotation_grid.sv
tb/sv/tb_grid_pkg.sv
tb/sv/tb_top.sv
